// ----- hdl/efr_pkg.sv -----
`default_nettype none
package efr_pkg;

  // Frame store geometry
  localparam int BUF_DEPTH = 32;
  localparam int IDX_W     = $clog2(BUF_DEPTH);
  localparam int FILL_W    = $clog2(BUF_DEPTH + 1);

  // Configuration port geometry
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  // Register indexes (byte address 4*i)
  localparam logic [2:0] REG_AUTO_ACK = 3'd0;
  localparam logic [2:0] REG_STX      = 3'd1;
  localparam logic [2:0] REG_ETX      = 3'd2;
  localparam logic [2:0] REG_ESC      = 3'd3;
  localparam logic [2:0] REG_ENQ      = 3'd4;
  localparam logic [2:0] REG_ACK      = 3'd5;
  localparam logic [2:0] REG_NAK      = 3'd6;

  // Result kinds
  localparam logic [1:0] KIND_REPLY   = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_MARKER  = 2'd2;

  // Configuration seen by the receive logic
  typedef struct packed {
    logic       auto_ack;
    logic [7:0] stx_code;
    logic [7:0] etx_code;
    logic [7:0] esc_code;
    logic [7:0] enq_code;
    logic [7:0] ack_code;
    logic [7:0] nak_code;
  } cfg_t;

endpackage
`default_nettype wire

// ----- hdl/efr_ram.sv -----
`default_nettype none
module efr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, holds when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- hdl/efr_regs.sv -----
`default_nettype none
module efr_regs
  import efr_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  output cfg_t                    cfg
);

  logic       wr_en;
  logic [2:0] reg_idx;
  logic [7:0] rd_val;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[PADDR_W-1:2];

  // Write registers on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.auto_ack <= 1'b0;
      cfg.stx_code <= 8'd2;
      cfg.etx_code <= 8'd3;
      cfg.esc_code <= 8'd27;
      cfg.enq_code <= 8'd5;
      cfg.ack_code <= 8'd6;
      cfg.nak_code <= 8'd21;
    end else if (wr_en) begin
      case (reg_idx)
        REG_AUTO_ACK: cfg.auto_ack <= pwdata[0];
        REG_STX:      cfg.stx_code <= pwdata[7:0];
        REG_ETX:      cfg.etx_code <= pwdata[7:0];
        REG_ESC:      cfg.esc_code <= pwdata[7:0];
        REG_ENQ:      cfg.enq_code <= pwdata[7:0];
        REG_ACK:      cfg.ack_code <= pwdata[7:0];
        REG_NAK:      cfg.nak_code <= pwdata[7:0];
        default:      ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (reg_idx)
      REG_AUTO_ACK: rd_val = {7'd0, cfg.auto_ack};
      REG_STX:      rd_val = cfg.stx_code;
      REG_ETX:      rd_val = cfg.etx_code;
      REG_ESC:      rd_val = cfg.esc_code;
      REG_ENQ:      rd_val = cfg.enq_code;
      REG_ACK:      rd_val = cfg.ack_code;
      REG_NAK:      rd_val = cfg.nak_code;
      default:      rd_val = 8'd0;
    endcase
  end

  assign prdata = {{(PDATA_W-8){1'b0}}, rd_val};

endmodule
`default_nettype wire

// ----- hdl/escaped_frame_receiver_core.sv -----
`default_nettype none
// Byte-stuffed frame receiver with additive checksum.
// A byte is accepted only in S_IDLE; a byte that gives no result leaves it there, ready for the next byte.
// A byte that gives a reply moves it to S_REPLY, from which the reply is loaded once the output slot is free.
// Frame readout: each payload byte is a RAM read in S_READ, then an output load in S_EMIT; the marker is from S_MARK.
// Reset: default codes, empty frame, no escape pending; frame store not cleared.
module escaped_frame_receiver_core
  import efr_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [7:0]         rx_byte,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic      [1:0]         kind,
  output logic      [7:0]         data_byte,
  output logic                    last
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_REPLY = 5'b00010,
    S_READ  = 5'b00100,
    S_EMIT  = 5'b01000,
    S_MARK  = 5'b10000
  } state_t;

  cfg_t cfg;

  state_t            state, state_next;
  logic [FILL_W-1:0] fill_index, fill_index_next;
  logic              escape_pending, escape_pending_next;
  logic [7:0]        running_sum, running_sum_next;
  logic [7:0]        last_stored, last_stored_next;
  logic [7:0]        reply_byte, reply_byte_next;
  logic [IDX_W-1:0]  rd_idx, rd_idx_next;

  logic              take;
  logic              out_free;
  logic              is_full;
  logic              is_enq, is_stx, is_esc, is_etx, is_ctrl;
  logic              st_we;
  logic [7:0]        st_rdata;
  logic [7:0]        body_sum;
  logic [FILL_W-1:0] payload_cnt;
  logic [FILL_W-1:0] rd_idx_inc;

  // Configuration registers
  efr_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Frame store
  efr_ram #(
    .WIDTH (8),
    .DEPTH (BUF_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (fill_index[IDX_W-1:0]),
    .wdata (rx_byte),
    .re    (state == S_READ),
    .raddr (rd_idx),
    .rdata (st_rdata)
  );

  assign in_ready = (state == S_IDLE);
  assign take     = in_valid & in_ready;
  assign out_free = ~out_valid | out_ready;

  // Classify the received byte
  assign is_full     = (fill_index >= FILL_W'(BUF_DEPTH));
  assign is_enq      = (rx_byte == cfg.enq_code);
  assign is_stx      = (rx_byte == cfg.stx_code);
  assign is_esc      = (rx_byte == cfg.esc_code);
  assign is_etx      = (rx_byte == cfg.etx_code);
  assign is_ctrl     = is_enq | is_stx | is_esc | is_etx;
  assign body_sum    = running_sum - last_stored;
  assign payload_cnt = fill_index - FILL_W'(1);
  assign rd_idx_inc  = FILL_W'(rd_idx) + FILL_W'(1);

  // Store write: ordinary byte, or control byte after escape
  assign st_we = take & ~is_full & (~is_ctrl | escape_pending);

  // Receive sequencer
  always_comb begin
    state_next          = state;
    fill_index_next     = fill_index;
    escape_pending_next = escape_pending;
    running_sum_next    = running_sum;
    last_stored_next    = last_stored;
    reply_byte_next     = reply_byte;
    rd_idx_next         = rd_idx;

    if (st_we) begin
      fill_index_next  = fill_index + FILL_W'(1);
      running_sum_next = running_sum + rx_byte;
      last_stored_next = rx_byte;
    end

    case (state)
      S_IDLE: begin
        if (take) begin
          if (is_full) begin
            fill_index_next  = '0;
            running_sum_next = '0;
            reply_byte_next  = cfg.nak_code;
            state_next       = S_REPLY;
          end else if (is_ctrl) begin
            if (escape_pending) begin
              escape_pending_next = 1'b0;
            end else if (is_enq) begin
              fill_index_next  = '0;
              running_sum_next = '0;
              if (cfg.auto_ack) begin
                reply_byte_next = cfg.ack_code;
                state_next      = S_REPLY;
              end
            end else if (is_stx) begin
              fill_index_next  = '0;
              running_sum_next = '0;
            end else if (is_esc) begin
              escape_pending_next = 1'b1;
            end else if (fill_index == '0 || body_sum != last_stored) begin
              reply_byte_next = cfg.nak_code;
              state_next      = S_REPLY;
            end else begin
              rd_idx_next = '0;
              state_next  = (payload_cnt == '0) ? S_MARK : S_READ;
            end
          end
        end
      end
      S_REPLY: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      S_READ: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          rd_idx_next = rd_idx_inc[IDX_W-1:0];
          state_next  = (rd_idx_inc == payload_cnt) ? S_MARK : S_READ;
        end
      end
      S_MARK: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      fill_index     <= '0;
      escape_pending <= 1'b0;
      running_sum    <= '0;
      last_stored    <= '0;
    end else begin
      state          <= state_next;
      fill_index     <= fill_index_next;
      escape_pending <= escape_pending_next;
      running_sum    <= running_sum_next;
      last_stored    <= last_stored_next;
    end
  end

  always_ff @(posedge clk) begin
    reply_byte <= reply_byte_next;
    rd_idx     <= rd_idx_next;
  end

  // Output register: load a result when the slot is free
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= (state == S_REPLY) | (state == S_EMIT) | (state == S_MARK);
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      case (state)
        S_REPLY: begin
          kind      <= KIND_REPLY;
          data_byte <= reply_byte;
          last      <= 1'b1;
        end
        S_EMIT: begin
          kind      <= KIND_PAYLOAD;
          data_byte <= st_rdata;
          last      <= 1'b0;
        end
        S_MARK: begin
          kind      <= KIND_MARKER;
          data_byte <= 8'd0;
          last      <= 1'b1;
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps
module tb_top;
  import efr_pkg::*;

  // Control codes after reset
  localparam logic [7:0] DFLT_STX = 8'h02;
  localparam logic [7:0] DFLT_ETX = 8'h03;
  localparam logic [7:0] DFLT_ESC = 8'h1B;
  localparam logic [7:0] DFLT_ENQ = 8'h05;
  localparam logic [7:0] DFLT_ACK = 8'h06;
  localparam logic [7:0] DFLT_NAK = 8'h15;

  localparam int PHASES       = 6;
  localparam int PHASE_BYTES  = 60;
  localparam int SETTLE_CYC   = 10;
  localparam int LONG_HOLD    = 400;
  localparam int TAIL_CYC     = 100;

  // How a directed row is checked
  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_REPLY} row_chk_e;

  typedef struct packed {
    logic [7:0] rx;
    row_chk_e   chk;
    logic [7:0] reply;
  } dir_row_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;
  } frame_out_t;

  // Directed stimulus under the reset codes
  localparam int DIR_N = 25;
  localparam dir_row_t DIR_ROWS [0:DIR_N-1] = '{
    '{DFLT_ETX, CHK_REPLY, DFLT_NAK},  // empty frame right after reset
    '{DFLT_ENQ, CHK_NONE,  8'h00},     // enquiry, auto-ack off
    '{DFLT_STX, CHK_NONE,  8'h00},
    '{8'h00,    CHK_NONE,  8'h00},
    '{8'hFF,    CHK_NONE,  8'h00},
    '{8'hFF,    CHK_NONE,  8'h00},     // checksum of 00 FF
    '{DFLT_ETX, CHK_MODEL, 8'h00},
    '{DFLT_STX, CHK_NONE,  8'h00},
    '{DFLT_ESC, CHK_NONE,  8'h00},
    '{DFLT_ETX, CHK_NONE,  8'h00},     // stored literally
    '{DFLT_ESC, CHK_NONE,  8'h00},
    '{8'h41,    CHK_NONE,  8'h00},     // ordinary byte keeps escape pending
    '{DFLT_ENQ, CHK_NONE,  8'h00},     // stored literally
    '{8'h49,    CHK_NONE,  8'h00},
    '{DFLT_ETX, CHK_MODEL, 8'h00},
    '{DFLT_STX, CHK_NONE,  8'h00},
    '{8'h10,    CHK_NONE,  8'h00},
    '{8'h11,    CHK_NONE,  8'h00},     // bad checksum
    '{DFLT_ETX, CHK_REPLY, DFLT_NAK},
    '{DFLT_STX, CHK_NONE,  8'h00},
    '{DFLT_ESC, CHK_NONE,  8'h00},
    '{DFLT_ESC, CHK_NONE,  8'h00},     // escaped escape
    '{8'h1B,    CHK_NONE,  8'h00},
    '{DFLT_ETX, CHK_MODEL, 8'h00},
    '{DFLT_ETX, CHK_MODEL, 8'h00}      // the 1B before escaped the previous end, so this end fails the checksum
  };

  logic                clk;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;
  logic                in_valid;
  logic                in_ready;
  logic [7:0]          rx_byte;
  logic                out_valid;
  logic                out_ready;
  logic [1:0]          kind;
  logic [7:0]          data_byte;
  logic                last;

  // Receiver state mirror
  logic [7:0] m_store [0:BUF_DEPTH-1];
  int         m_fill;
  logic       m_esc_pend;
  logic [7:0] m_sum;
  logic [7:0] m_last_b;

  // Register mirror
  logic       m_auto_ack;
  logic [7:0] m_stx, m_etx, m_esc, m_enq, m_ack, m_nak;

  frame_out_t step_out [$];
  frame_out_t out_due [$];

  int fail_cnt;
  int bytes_sent;
  int tx_gap_pct;
  int rx_stall_pct;
  int hold_request;

  escaped_frame_receiver_core dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .rx_byte   (rx_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kind      (kind),
    .data_byte (data_byte),
    .last      (last)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Queue one result of the current byte
  function automatic void emit(input logic [1:0] k, input logic [7:0] d);
    frame_out_t r;
    r.kind = k;
    r.data = d;
    r.last = 1'b0;
    step_out.push_back(r);
  endfunction

  function automatic void stash(input logic [7:0] b);
    m_store[m_fill] = b;
    m_fill++;
    m_sum = m_sum + b;
    m_last_b = b;
  endfunction

  // Advance the receiver mirror by one byte, leaving its results in step_out
  function automatic void frame_rx_predict(input logic [7:0] b);
    logic [7:0] body;
    if (m_fill >= BUF_DEPTH) begin
      emit(KIND_REPLY, m_nak);
      m_fill = 0;
      m_sum = 8'h00;
    end else if (b == m_enq || b == m_stx || b == m_esc || b == m_etx) begin
      if (m_esc_pend) begin
        stash(b);
        m_esc_pend = 1'b0;
      end else if (b == m_enq) begin
        m_fill = 0;
        m_sum = 8'h00;
        if (m_auto_ack) emit(KIND_REPLY, m_ack);
      end else if (b == m_stx) begin
        m_fill = 0;
        m_sum = 8'h00;
      end else if (b == m_esc) begin
        m_esc_pend = 1'b1;
      end else if (m_fill == 0) begin
        emit(KIND_REPLY, m_nak);
      end else begin
        body = m_sum - m_last_b;
        if (body != m_last_b) begin
          emit(KIND_REPLY, m_nak);
        end else begin
          for (int i = 0; i + 1 < m_fill; i++) emit(KIND_PAYLOAD, m_store[i]);
          emit(KIND_MARKER, 8'h00);
        end
      end
    end else begin
      stash(b);
    end
    if (step_out.size() > 0) step_out[step_out.size()-1].last = 1'b1;
  endfunction

  function automatic logic is_ctrl(input logic [7:0] d);
    return d == m_stx || d == m_etx || d == m_esc || d == m_enq;
  endfunction

  // Offer one byte, hold it until the transaction completes, then log its results
  task automatic send_byte(input logic [7:0] b, input row_chk_e chk = CHK_MODEL,
                           input logic [7:0] reply = 8'h00);
    frame_out_t r;
    while ($urandom_range(99) < tx_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!in_ready);
    frame_rx_predict(b);
    case (chk)
      CHK_MODEL: foreach (step_out[i]) out_due.push_back(step_out[i]);
      CHK_REPLY: begin
        r.kind = KIND_REPLY;
        r.data = reply;
        r.last = 1'b1;
        out_due.push_back(r);
      end
      default: ;
    endcase
    step_out.delete();
    bytes_sent++;
    @(negedge clk);
  endtask

  // Send a data byte, escaping it when it collides with a control code (only sometimes unless clean)
  task automatic send_data(input logic [7:0] d, input bit clean);
    if (is_ctrl(d) && (clean || $urandom_range(7) != 0)) send_byte(m_esc);
    send_byte(d);
  endtask

  // One frame: start, payload, checksum, end; len < 0 picks a random size; unclean frames may differ
  task automatic send_frame(input int len, input bit clean);
    logic [7:0] d;
    logic [7:0] ck;
    int         n;
    int         r;
    n = len;
    if (n < 0) begin
      r = $urandom_range(99);
      if (r < 70)      n = $urandom_range(8);
      else if (r < 92) n = $urandom_range(31, 9);
      else             n = $urandom_range(34, 32);
    end
    if (!clean && $urandom_range(19) == 0) begin
      send_byte(m_stx);
      send_byte(m_etx);
      return;
    end
    send_byte((!clean && $urandom_range(7) == 0) ? m_enq : m_stx);
    ck = 8'h00;
    for (int i = 0; i < n; i++) begin
      d = 8'($urandom_range(255));
      ck = ck + d;
      send_data(d, clean);
    end
    if (!clean && $urandom_range(5) == 0) ck = ck ^ 8'(1 << $urandom_range(7));
    send_data(ck, clean);
    send_byte(m_etx);
  endtask

  // Loose bytes between frames
  task automatic send_noise();
    int n;
    n = $urandom_range(4, 1);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) send_byte(m_enq);
      else send_byte(8'($urandom_range(255)));
    end
  endtask

  // Register write: setup cycle, then access cycle until pready
  task automatic reg_write(input logic [2:0] idx, input logic [7:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({idx, 2'b00});
    pwdata  <= PDATA_W'(val);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_AUTO_ACK: m_auto_ack = val[0];
      REG_STX:      m_stx = val;
      REG_ETX:      m_etx = val;
      REG_ESC:      m_esc = val;
      REG_ENQ:      m_enq = val;
      REG_ACK:      m_ack = val;
      REG_NAK:      m_nak = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic apply_codes(input logic aa, input logic [7:0] s, input logic [7:0] e,
                             input logic [7:0] x, input logic [7:0] q,
                             input logic [7:0] a, input logic [7:0] n);
    reg_write(REG_AUTO_ACK, {7'd0, aa});
    reg_write(REG_STX, s);
    reg_write(REG_ETX, e);
    reg_write(REG_ESC, x);
    reg_write(REG_ENQ, q);
    reg_write(REG_ACK, a);
    reg_write(REG_NAK, n);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Drop valid and wait until every result is in and the block is quiet
  task automatic drain(input int settle);
    in_valid <= 1'b0;
    while (out_due.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
    @(negedge clk);
  endtask

  // Output side: random stalls, plus a long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // Compare each output transaction with the oldest expected result
  always @(posedge clk) begin
    frame_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (out_due.size() == 0) begin
        $error("unexpected result: kind %0d data_byte 0x%02h last %0d",
               kind, data_byte, last);
        fail_cnt++;
      end else begin
        want = out_due.pop_front();
        if (kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, kind);
          fail_cnt++;
        end
        if (data_byte !== want.data) begin
          $error("data_byte: expected 0x%02h, got 0x%02h", want.data, data_byte);
          fail_cnt++;
        end
        if (last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, last);
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    fail_cnt     = 0;
    bytes_sent   = 0;
    tx_gap_pct   = 0;
    rx_stall_pct = 0;
    hold_request = 0;
    rst      = 1'b1;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    in_valid = 1'b0;
    rx_byte  = 8'h00;
    // Mirror of the reset state
    m_fill     = 0;
    m_esc_pend = 1'b0;
    m_sum      = 8'h00;
    m_last_b   = 8'h00;
    m_auto_ack = 1'b0;
    m_stx = DFLT_STX;
    m_etx = DFLT_ETX;
    m_esc = DFLT_ESC;
    m_enq = DFLT_ENQ;
    m_ack = DFLT_ACK;
    m_nak = DFLT_NAK;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed rows
    for (int i = 0; i < DIR_N; i++) send_byte(DIR_ROWS[i].rx, DIR_ROWS[i].chk, DIR_ROWS[i].reply);

    // Random phases, each with its own codes; the idle pattern repeats every four phases
    for (int ph = 0; ph < PHASES; ph++) begin
      drain(SETTLE_CYC);
      case (ph)
        0: apply_codes(1'b1, DFLT_STX, DFLT_ETX, DFLT_ESC, DFLT_ENQ, DFLT_ACK, DFLT_NAK);
        1: apply_codes(1'b1, 8'h00, 8'hFF, 8'h80, 8'h7F, 8'hFF, 8'h00);
        2: apply_codes(1'b0, 8'hFE, 8'h01, 8'h7E, 8'h81, 8'h00, 8'hFF);
        3: apply_codes(1'b1, 8'h10, 8'h12, 8'h11, 8'h10, 8'hAA, 8'h55); // start equals enquiry
        4: apply_codes(1'b1, 8'h40, 8'h41, 8'h41, 8'h42, 8'h5A, 8'hA5); // end equals escape
        default: apply_codes(1'($urandom_range(1)), 8'($urandom_range(255)),
                             8'($urandom_range(255)), 8'($urandom_range(255)),
                             8'($urandom_range(255)), 8'($urandom_range(255)),
                             8'($urandom_range(255)));
      endcase
      case (ph % 4)
        0: begin tx_gap_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_gap_pct = 49; rx_stall_pct = 0;  end
        2: begin tx_gap_pct = 0;  rx_stall_pct = 49; end
        default: begin tx_gap_pct = 29; rx_stall_pct = 29; end
      endcase
      bytes_sent = 0;
      // Back up the output with long frames while the receiver holds off
      if (ph == 2) begin
        hold_request = LONG_HOLD;
        repeat (3) send_frame(31, 1'b1);
      end
      while (bytes_sent < PHASE_BYTES) begin
        if ($urandom_range(99) < 80) send_frame(-1, 1'b0);
        else send_noise();
      end
    end

    drain(TAIL_CYC);
    if (fail_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
